/* rtl/core/rcpc_adc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcpc_adc_pkg
// Shared types, constants and helpers of the RC pulse-counting converter.
// ----------------------------------------------------------------------------
package rcpc_adc_pkg;

    localparam int CHANNELS  = 8;
    localparam int CH_W      = $clog2(CHANNELS);
    localparam int COUNT_W   = 32;
    localparam int SAMPLE_W  = 12;
    localparam int THR_W     = 12;
    localparam int MEAS_W    = 32;
    localparam int APB_DW    = 32;
    localparam int APB_AW    = 3;

    localparam logic [THR_W-1:0] CHG_THR_RESET = THR_W'(2589);
    localparam logic [THR_W-1:0] DIS_THR_RESET = THR_W'(1508);

    // item kinds carried on s_tuser
    localparam logic OP_SAMPLE     = 1'b0;
    localparam logic OP_SET_ACTIVE = 1'b1;

    // register index, taken from paddr[2]
    localparam logic REG_CHG_THR = 1'b0;
    localparam logic REG_DIS_THR = 1'b1;

    // one memory word per channel
    typedef struct packed {
        logic               active;
        logic               charging;
        logic [COUNT_W-1:0] chg_count;
        logic [COUNT_W-1:0] dis_count;
        logic [COUNT_W-1:0] chg_avg;
        logic [COUNT_W-1:0] dis_avg;
    } chan_entry_t;

    // what the update stage hands to the measurement stage
    typedef struct packed {
        logic               issued;
        logic               high;
        logic               crossed;
        logic               charging_after;
        logic               meas_en;
        logic [COUNT_W-1:0] chg_avg;
        logic [COUNT_W-1:0] dis_avg;
    } res_stage_t;

    // floor((a + b + ci) / 2) with one extra sum bit
    function automatic logic [COUNT_W-1:0] half_sum(
        input logic [COUNT_W-1:0] a,
        input logic [COUNT_W-1:0] b,
        input logic               ci
    );
        logic [COUNT_W:0] sum;
        sum = {1'b0, a} + {1'b0, b} + (COUNT_W+1)'(ci);
        return sum[COUNT_W:1];
    endfunction

endpackage

/* rtl/core/rc_pulse_count_soft_adc_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rc_pulse_count_soft_adc_core
// Multi-channel RC pulse-counting converter with per-channel state in memory.
// ----------------------------------------------------------------------------
// Usage:
//   s_* stream carries one item per transfer: s_tuser selects a sample item or
//   a set-activity item, s_tdata holds channel, sample and enable. Every item
//   gives exactly one result on the m_* stream, in order.
//   Thresholds are written through the APB port while the stream is idle.
// Throughput and pipeline:
//   one item per cycle sustained while m_tready is high; each item passes a
//   registered memory read, then channel update and write-back, then
//   measurement add into the output register.
//   Per-channel state sits in an 8-entry synchronous memory; back-to-back
//   items on the same channel are served by forwarding the word just written.
// Reset:
//   all channels read as inactive and cleared, thresholds return to their
//   defaults; no clearing pass, so the block is ready right after reset.
// Stall:
//   when m_tready is low the output holds; the two internal stages still fill,
//   then s_tready drops until the output drains.
// ----------------------------------------------------------------------------
module rc_pulse_count_soft_adc_core (
    input  logic                           clk,
    input  logic                           rst_n,
    // input stream
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [15:0]                    s_tdata,   // channel[2:0], sample[14:3], enable[15]
    input  logic                           s_tuser,   // operation
    // result stream
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // drive_issued[0], drive_high[1], threshold_crossed[2], charging_after[3],
    // measurement[35:4], zero fill[39:36]
    output logic [39:0]                    m_tdata,
    // configuration
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [rcpc_adc_pkg::APB_AW-1:0] paddr,
    input  logic [rcpc_adc_pkg::APB_DW-1:0] pwdata,
    output logic [rcpc_adc_pkg::APB_DW-1:0] prdata,
    output logic                           pready
);
    import rcpc_adc_pkg::*;

    // configuration registers
    logic [THR_W-1:0] chg_thr_reg;
    logic [THR_W-1:0] dis_thr_reg;
    logic             cfg_wr;

    // channel memory and its valid bits
    chan_entry_t      mem [CHANNELS];
    logic [CHANNELS-1:0] valid_reg;
    chan_entry_t      rd_data_reg;
    logic             rd_valid_reg;

    // update stage
    logic             s1_valid_reg;
    logic             s1_op_reg;
    logic [CH_W-1:0]  s1_ch_reg;
    logic [SAMPLE_W-1:0] s1_sample_reg;
    logic             s1_enable_reg;
    logic             fwd_hit_reg;
    chan_entry_t      fwd_data_reg;
    chan_entry_t      cur;
    chan_entry_t      s1_next;
    res_stage_t       s1_res;
    logic             cnt_sat;

    // measurement stage and output
    logic             s2_valid_reg;
    res_stage_t       s2_res_reg;
    logic             m_valid_reg;
    logic [39:0]      m_data_reg;
    logic [MEAS_W-1:0] meas;

    logic             adv_out;
    logic             adv_s2;
    logic             adv_s1;
    logic             mem_wr;
    logic [CH_W-1:0]  in_ch;

    assign adv_out  = !m_valid_reg || m_tready;
    assign adv_s2   = !s2_valid_reg || adv_out;
    assign adv_s1   = !s1_valid_reg || adv_s2;
    assign s_tready = adv_s1;
    assign mem_wr   = s1_valid_reg && adv_s2;
    assign in_ch    = s_tdata[CH_W-1:0];

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // ------------------------------------------------------------------
    // APB registers
    // ------------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chg_thr_reg <= CHG_THR_RESET;
            dis_thr_reg <= DIS_THR_RESET;
        end
        else if (cfg_wr)
        begin
            case (paddr[2])
                REG_CHG_THR: chg_thr_reg <= pwdata[THR_W-1:0];
                REG_DIS_THR: dis_thr_reg <= pwdata[THR_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_CHG_THR: prdata = APB_DW'(chg_thr_reg);
            REG_DIS_THR: prdata = APB_DW'(dis_thr_reg);
            default:     prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // channel memory: registered read on transfer, write-back from update
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (mem_wr)
        begin
            mem[s1_ch_reg] <= s1_next;
        end
        if (adv_s1)
        begin
            rd_data_reg <= mem[in_ch];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
            fwd_hit_reg  <= 1'b0;
        end
        else
        begin
            if (mem_wr)
            begin
                valid_reg[s1_ch_reg] <= 1'b1;
            end
            if (adv_s1)
            begin
                rd_valid_reg <= valid_reg[in_ch];
                // word written at this same edge is not yet in the read data
                fwd_hit_reg  <= mem_wr && (s1_ch_reg == in_ch);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv_s1)
        begin
            fwd_data_reg  <= s1_next;
            s1_op_reg     <= s_tuser;
            s1_ch_reg     <= in_ch;
            s1_sample_reg <= s_tdata[CH_W+SAMPLE_W-1:CH_W];
            s1_enable_reg <= s_tdata[CH_W+SAMPLE_W];
        end
    end

    // ------------------------------------------------------------------
    // channel update
    // ------------------------------------------------------------------
    assign cur = fwd_hit_reg ? fwd_data_reg : (rd_valid_reg ? rd_data_reg : '0);

    always_comb
    begin
        s1_next = cur;
        s1_res  = '0;
        cnt_sat = 1'b0;
        case (s1_op_reg)
            OP_SET_ACTIVE:
            begin
                s1_next        = '0;
                s1_next.active = s1_enable_reg;
            end
            OP_SAMPLE:
            begin
                s1_res.charging_after = cur.charging;
                if (cur.active)
                begin
                    s1_res.issued  = 1'b1;
                    s1_res.meas_en = 1'b1;
                    if (cur.charging)
                    begin
                        s1_res.high = 1'b1;
                        cnt_sat     = &cur.chg_count;
                        if (s1_sample_reg >= chg_thr_reg)
                        begin
                            s1_res.crossed    = 1'b1;
                            s1_next.charging  = 1'b0;
                            // incremented count folded in with the carry-in
                            s1_next.chg_avg   = half_sum(cur.chg_avg, cur.chg_count, !cnt_sat);
                            s1_next.chg_count = '0;
                        end
                        else if (!cnt_sat)
                        begin
                            s1_next.chg_count = cur.chg_count + COUNT_W'(1);
                        end
                    end
                    else
                    begin
                        cnt_sat = &cur.dis_count;
                        if (s1_sample_reg <= dis_thr_reg)
                        begin
                            s1_res.crossed    = 1'b1;
                            s1_next.charging  = 1'b1;
                            s1_next.dis_avg   = half_sum(cur.dis_avg, cur.dis_count, !cnt_sat);
                            s1_next.dis_count = '0;
                        end
                        else if (!cnt_sat)
                        begin
                            s1_next.dis_count = cur.dis_count + COUNT_W'(1);
                        end
                    end
                    s1_res.charging_after = s1_next.charging;
                    s1_res.chg_avg        = s1_next.chg_avg;
                    s1_res.dis_avg        = s1_next.dis_avg;
                end
            end
            default: ;
        endcase
    end

    // ------------------------------------------------------------------
    // measurement stage and output register
    // ------------------------------------------------------------------
    assign meas = s2_res_reg.meas_en
                ? MEAS_W'(half_sum(s2_res_reg.chg_avg, s2_res_reg.dis_avg, 1'b0))
                : '0;

    always_ff @(posedge clk)
    begin
        if (adv_s2)
        begin
            s2_res_reg <= s1_res;
        end
        if (adv_out)
        begin
            m_data_reg <= {4'b0000, meas, s2_res_reg.charging_after,
                           s2_res_reg.crossed, s2_res_reg.high, s2_res_reg.issued};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end
        else
        begin
            if (adv_s1)
            begin
                s1_valid_reg <= s_tvalid;
            end
            if (adv_s2)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (adv_out)
            begin
                m_valid_reg <= s2_valid_reg;
            end
        end
    end

`ifndef SYNTH
    // input is refused only when every stage holds an item
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (s1_valid_reg && s2_valid_reg && m_valid_reg))
    else $error("input stalled with a free stage");

    // no pulse means no pulse level and no phase end
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tdata[0]) |-> (!m_tdata[1] && !m_tdata[2]))
    else $error("pulse flags set without a drive pulse");

    // a written channel reads back as valid from then on
    assert property (@(posedge clk) disable iff (!rst_n)
        mem_wr |=> valid_reg[$past(s1_ch_reg)])
    else $error("channel valid bit not set after write-back");
`endif

endmodule
